// ----- rtl/lqsm_pkg.sv -----
// Link quality and stability monitor: shared sizes, codes and scoring functions.
// Depends on nothing; every other file but lqsm_if imports it.
`timescale 1ns / 1ps
package lqsm_pkg;

    localparam int HISTORY_DEPTH = 100;
    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = 9 + CNT_W;
    localparam int SQ_W    = 17 + CNT_W;
    localparam int D_W     = CNT_W + SQ_W;
    localparam int X_W     = D_W + 10;
    localparam int R_W     = (X_W + 1) / 2;
    localparam int MNUM_W  = SUM_W + 6;
    localparam int DIV_NW  = (MNUM_W > R_W) ? MNUM_W : R_W;
    localparam int DIV_DW  = CNT_W + 1;
    localparam int MEAN_W  = 13;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANGES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAB_THR    = 4'd1;

    localparam logic [15:0] RST_MAX_CHANGES = 16'd5;
    localparam logic [10:0] RST_STAB_THR    = 11'd1280;
    localparam logic [10:0] STAB_FULL       = 11'd1600;

    typedef struct packed {
        logic signed [8:0] rsrp_dbm;
        logic signed [6:0] rsrq_db;
        logic signed [6:0] sinr_db;
        logic              rsrp_valid;
        logic              rsrq_valid;
        logic              sinr_valid;
        logic              roaming;
        logic              connected;
        logic [15:0]       seconds_since_cell_change;
        logic [15:0]       cell_changes_seen;
    } meas_t;

    function automatic logic [6:0] quality_of(meas_t m);
        logic signed [8:0] q;
        q = 9'sd100;
        if (m.rsrp_valid) begin
            if (m.rsrp_dbm >= -9'sd80) q = q;
            else if (m.rsrp_dbm >= -9'sd90) q = q - 9'sd5;
            else if (m.rsrp_dbm >= -9'sd100) q = q - 9'sd15;
            else if (m.rsrp_dbm >= -9'sd110) q = q - 9'sd30;
            else q = q - 9'sd50;
        end
        if (m.rsrq_valid) begin
            if (m.rsrq_db >= -7'sd10) q = q;
            else if (m.rsrq_db >= -7'sd15) q = q - 9'sd5;
            else if (m.rsrq_db >= -7'sd20) q = q - 9'sd15;
            else q = q - 9'sd25;
        end
        if (m.sinr_valid) begin
            if (m.sinr_db >= 7'sd20) q = q + 9'sd10;
            else if (m.sinr_db >= 7'sd13) q = q + 9'sd5;
            else if (m.sinr_db < 7'sd0) q = q - 9'sd20;
        end
        if (m.roaming) q = q - 9'sd10;
        if (q < 9'sd0) q = 9'sd0;
        if (q > 9'sd100) q = 9'sd100;
        return q[6:0];
    endfunction

    function automatic logic [10:0] stab_score_of(meas_t m, logic [10:0] stab);
        logic signed [12:0] s;
        s = $signed({2'b00, stab});
        if (m.seconds_since_cell_change < 16'd300) s = s - 13'sd320;
        else if (m.seconds_since_cell_change < 16'd600) s = s - 13'sd160;
        if (!m.connected) s = s - 13'sd800;
        if (s < 13'sd0) s = 13'sd0;
        return s[10:0];
    endfunction

    function automatic logic [3:0] risk_of(meas_t m, logic [10:0] stab,
                                           logic [15:0] max_chg, logic [10:0] thr);
        logic [3:0] r;
        r = 4'd0;
        if (m.rsrp_valid) begin
            if (m.rsrp_dbm < -9'sd110) r = r + 4'd4;
            else if (m.rsrp_dbm < -9'sd100) r = r + 4'd2;
        end
        if (m.rsrq_valid) begin
            if (m.rsrq_db < -7'sd20) r = r + 4'd3;
            else if (m.rsrq_db < -7'sd15) r = r + 4'd1;
        end
        if (m.cell_changes_seen > max_chg) r = r + 4'd2;
        if (stab < thr) r = r + 4'd1;
        return r;
    endfunction

endpackage

// ----- rtl/lqsm_if.sv -----
// Channel interfaces: measurement input, result output, configuration writes.
// Depends on nothing.
`timescale 1ns / 1ps
interface lqsm_meas_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] rsrp_dbm;
    logic signed [6:0] rsrq_db;
    logic signed [6:0] sinr_db;
    logic              rsrp_valid;
    logic              rsrq_valid;
    logic              sinr_valid;
    logic              roaming;
    logic              connected;
    logic [15:0]       seconds_since_cell_change;
    logic [15:0]       cell_changes_seen;
    modport source (output valid, rsrp_dbm, rsrq_db, sinr_db, rsrp_valid, rsrq_valid,
                    sinr_valid, roaming, connected, seconds_since_cell_change,
                    cell_changes_seen, input ready);
    modport sink   (input valid, rsrp_dbm, rsrq_db, sinr_db, rsrp_valid, rsrq_valid,
                    sinr_valid, roaming, connected, seconds_since_cell_change,
                    cell_changes_seen, output ready);
endinterface

interface lqsm_res_if;
    logic               valid;
    logic               ready;
    logic [6:0]         quality_score;
    logic [10:0]        stab_score;
    logic [10:0]        variance_stability;
    logic signed [12:0] mean_rsrp;
    logic [3:0]         risk_tenths;
    modport source (output valid, quality_score, stab_score, variance_stability,
                    mean_rsrp, risk_tenths, input ready);
    modport sink   (input valid, quality_score, stab_score, variance_stability,
                    mean_rsrp, risk_tenths, output ready);
endinterface

interface lqsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/lqsm_ring.sv -----
// RSRP history memory: one write port, one registered read port.
// Depends on lqsm_pkg.
`timescale 1ns / 1ps
module lqsm_ring
    import lqsm_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [8:0]       wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [8:0]       rdata
);
    logic [8:0] mem [HISTORY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/lqsm_divu.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on lqsm_pkg.
`timescale 1ns / 1ps
module lqsm_divu
    import lqsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_NW-1:0] quot
);
    localparam int C_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quot_reg, quot_next;
    logic [DIV_DW-1:0] rem_reg, rem_next, den_reg;
    logic [C_W-1:0]    cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DIV_DW:0]   rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[DIV_NW-1]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next  = DIV_DW'(rem_sh - {1'b0, den_reg});
                quot_next = {quot_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[DIV_DW-1:0];
                quot_next = {quot_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = C_W'(cnt_reg + 1'b1);
            if (cnt_reg == C_W'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ----- rtl/lqsm_isqrt.sv -----
// Integer square root, digit by digit, one root bit per cycle.
// Depends on lqsm_pkg.
`timescale 1ns / 1ps
module lqsm_isqrt
    import lqsm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [X_W-1:0] x,
    output logic           done,
    output logic [R_W-1:0] root
);
    localparam int C_W  = $clog2(R_W + 1);
    localparam int RM_W = R_W + 2;

    logic [2*R_W-1:0] x_reg, x_next;
    logic [R_W-1:0]   root_reg, root_next;
    logic [RM_W-1:0]  rem_reg, rem_next;
    logic [C_W-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [RM_W+1:0]  rem_sh, trial;

    always_comb
    begin
        rem_sh    = {rem_reg, x_reg[2*R_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        x_next    = x_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = (2*R_W)'(x);
            root_next = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[2*R_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = RM_W'(rem_sh - trial);
                root_next = {root_reg[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RM_W'(rem_sh);
                root_next = {root_reg[R_W-2:0], 1'b0};
            end
            cnt_next = C_W'(cnt_reg + 1'b1);
            if (cnt_reg == C_W'(R_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ----- rtl/link_quality_stability_monitor.sv -----
// Link quality and stability monitor, top level: control sequencer and scoring.
// Depends on lqsm_pkg, lqsm_if, lqsm_ring, lqsm_divu, lqsm_isqrt.
//
// Usage:
//   meas: one radio measurement per transaction (valid/ready).
//   res : one result per measurement, held in an output register until taken.
//   cfg : register writes, index 0 = cell change limit, 1 = variance stability
//         threshold; always ready, write only while the block is idle.
// A measurement with all three valid flags set is stored in the RSRP history
// ring; with two or more entries held, the ring is walked once through its
// single read port, then mean and deviation go through one shared restoring
// divider (used twice) and a bit-serial square root; the result register
// loads once the second division is done. With no history update the
// sequencer goes from acceptance straight to its done state and loads there.
// meas.ready is high only while the sequencer is idle; one item at a time,
// the next one is taken the cycle after the result register loads.
// If res is stalled the finished result waits in the sequencer and the
// output register; nothing is dropped.
// Reset clears the fill count, write slot, stability and mean to zero and
// loads the register defaults; the ring itself is not cleared.
`timescale 1ns / 1ps
module link_quality_stability_monitor
    import lqsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lqsm_meas_if.sink   meas,
    lqsm_res_if.source  res,
    lqsm_cfg_if.sink    cfg
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_DIVM  = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_DIVT  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]  state_reg, state_next;
    meas_t       item_reg;
    logic [15:0] max_chg_reg;
    logic [10:0] thr_reg;
    logic [IDX_W-1:0] slot_reg, rd_idx_reg;
    logic [CNT_W-1:0] held_reg;
    logic        rd_pend_reg;
    logic [10:0] stab_reg;
    logic signed [MEAN_W-1:0] mean_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sumsq_reg;
    logic [D_W-1:0]          p1_reg;
    logic [2*SUM_W-1:0]      p2_reg;
    logic [D_W-1:0]          d_reg;
    logic                    neg_reg;

    logic        accept, all_valid, ring_we;
    logic [8:0]  rdata;
    logic        out_valid_reg;
    logic        out_free;

    logic              div_start, div_done, sq_start, sq_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den;
    logic [R_W-1:0]    sq_root;
    logic [R_W-1:0]    root_reg;
    logic              root_seen;

    logic signed [MNUM_W:0] mnum, mmag;
    logic [2*SUM_W-1:0]     diff;
    logic signed [8:0]      rv;
    logic signed [17:0]     rsq;

    assign all_valid = meas.rsrp_valid & meas.rsrq_valid & meas.sinr_valid;
    assign accept    = meas.valid & meas.ready;
    assign meas.ready = (state_reg == S_IDLE);
    assign ring_we   = accept & all_valid;
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || res.ready;

    lqsm_ring u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (meas.rsrp_dbm),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    // Mean numerator 32*S + n; floor division via magnitude and bias.
    assign mnum = ($signed({{(MNUM_W-SUM_W-4){sum_reg[SUM_W-1]}}, sum_reg, 5'b0}))
                  + $signed({1'b0, (MNUM_W)'(held_reg)});
    assign mmag = mnum[MNUM_W] ? ((-mnum) + $signed((MNUM_W+1)'({held_reg, 1'b0}))
                                  - (MNUM_W+1)'(1)) : mnum;
    assign diff = (2*SUM_W)'(p1_reg) - p2_reg;
    assign rv   = $signed(rdata);
    assign rsq  = rv * rv;

    assign div_start = (state_reg == S_DIFF) || (state_reg == S_SQRT && sq_done);
    assign div_num   = (state_reg == S_DIFF) ? DIV_NW'(mmag[MNUM_W-1:0])
                                             : DIV_NW'(sq_root);
    assign div_den   = (state_reg == S_DIFF) ? {held_reg, 1'b0} : DIV_DW'(held_reg);
    assign sq_start  = (state_reg == S_DIVM) && div_done;

    lqsm_divu u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    lqsm_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     ({d_reg, 10'b0}),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (all_valid && held_reg != '0) state_next = S_SWEEP;
                    else state_next = S_DONE;
                end
            end
            S_SWEEP:
            begin
                if (CNT_W'(rd_idx_reg) == CNT_W'(held_reg - 1'b1)) state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_MUL;
            S_MUL:   state_next = S_DIFF;
            S_DIFF:  state_next = S_DIVM;
            S_DIVM:  if (div_done) state_next = S_SQRT;
            S_SQRT:  if (sq_done) state_next = S_DIVT;
            S_DIVT:  if (div_done) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            held_reg      <= '0;
            stab_reg      <= '0;
            mean_reg      <= '0;
            max_chg_reg   <= RST_MAX_CHANGES;
            thr_reg       <= RST_STAB_THR;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                if (cfg.index == CFG_MAX_CHANGES) max_chg_reg <= cfg.data;
                else if (cfg.index == CFG_STAB_THR) thr_reg <= cfg.data[10:0];
            end
            if (ring_we)
            begin
                slot_reg <= (slot_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                            : IDX_W'(slot_reg + 1'b1);
                if (held_reg != CNT_W'(HISTORY_DEPTH))
                begin
                    held_reg <= CNT_W'(held_reg + 1'b1);
                end
            end
            rd_pend_reg <= (state_reg == S_SWEEP);
            if (state_reg == S_SWEEP) rd_idx_reg <= IDX_W'(rd_idx_reg + 1'b1);
            else rd_idx_reg <= '0;
            if (state_reg == S_DIVM && div_done)
            begin
                mean_reg <= neg_reg ? MEAN_W'(-div_quot) : MEAN_W'(div_quot);
            end
            if (state_reg == S_DIVT && div_done)
            begin
                stab_reg <= (div_quot >= DIV_NW'(STAB_FULL)) ? '0
                            : 11'(STAB_FULL - 11'(div_quot));
            end
            if (state_reg == S_DONE && out_free) out_valid_reg <= 1'b1;
            else if (res.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.rsrp_dbm   <= meas.rsrp_dbm;
            item_reg.rsrq_db    <= meas.rsrq_db;
            item_reg.sinr_db    <= meas.sinr_db;
            item_reg.rsrp_valid <= meas.rsrp_valid;
            item_reg.rsrq_valid <= meas.rsrq_valid;
            item_reg.sinr_valid <= meas.sinr_valid;
            item_reg.roaming    <= meas.roaming;
            item_reg.connected  <= meas.connected;
            item_reg.seconds_since_cell_change <= meas.seconds_since_cell_change;
            item_reg.cell_changes_seen <= meas.cell_changes_seen;
        end
        if (state_reg == S_IDLE)
        begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            sum_reg   <= SUM_W'(sum_reg + SUM_W'(rv));
            sumsq_reg <= SQ_W'(sumsq_reg + SQ_W'(rsq[16:0]));
        end
        if (state_reg == S_MUL)
        begin
            p1_reg <= D_W'(held_reg) * D_W'(sumsq_reg);
            p2_reg <= $unsigned((2*SUM_W)'(sum_reg) * (2*SUM_W)'(sum_reg));
        end
        if (state_reg == S_DIFF)
        begin
            d_reg   <= diff[D_W-1:0];
            neg_reg <= mnum[MNUM_W];
        end
        if (state_reg == S_SQRT && sq_done) root_reg <= sq_root;
        if (state_reg == S_DONE && out_free)
        begin
            res.quality_score      <= quality_of(item_reg);
            res.stab_score         <= stab_score_of(item_reg, stab_reg);
            res.variance_stability <= stab_reg;
            res.mean_rsrp          <= mean_reg;
            res.risk_tenths        <= risk_of(item_reg, stab_reg, max_chg_reg, thr_reg);
        end
    end

    assign res.valid = out_valid_reg;

    // The sqrt result feeds the second division directly; keep a copy for debug.
    assign root_seen = |root_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("history fill count beyond depth");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < IDX_W'(HISTORY_DEPTH))
        else $error("write slot beyond depth");

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWEEP |-> CNT_W'(rd_idx_reg) < held_reg)
        else $error("ring walk reads past held entries");

    a_no_ring_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> state_reg == S_IDLE)
        else $error("ring written while a recompute is running");

    a_sqrt_root_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT && sq_done) |=> (state_reg == S_DIVT) && (root_seen == |sq_root))
        else $error("square root not handed to divider");
endmodule

// ----- dv/link_quality_stability_monitor_tb.sv -----
// Self-checking testbench for link_quality_stability_monitor.
// Depends on rtl/lqsm_pkg.sv, rtl/lqsm_if.sv, the top level and the RTL below it.
// Directed table first, then random measurements checked against a behavioral predictor.
`timescale 1ns / 1ps
module link_quality_stability_monitor_tb;
    import lqsm_pkg::*;

    typedef struct packed {
        logic [6:0]         quality;
        logic [10:0]        stab_score;
        logic [10:0]        var_stab;
        logic signed [12:0] mean;
        logic [3:0]         risk;
    } score_t;

    typedef struct packed {
        meas_t  m;
        logic   typed;
        score_t s;
    } vec_t;

    logic clk;
    logic rst_n;
    lqsm_meas_if meas ();
    lqsm_res_if  res ();
    lqsm_cfg_if  cfg ();

    link_quality_stability_monitor dut (
        .clk  (clk),
        .rst_n(rst_n),
        .meas (meas.sink),
        .res  (res.source),
        .cfg  (cfg.sink)
    );

    // predictor state
    int          hist_ring [HISTORY_DEPTH];
    int          slot_ptr;
    int          fill_cnt;
    int          stab_val;
    int          mean_val;
    int unsigned chg_limit;
    int unsigned stab_thr;

    score_t      score_q [$];
    int          n_errors;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    longint      cycles;
    vec_t        dir_tab [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // floor division, positive divisor
    function automatic longint div_floor(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic void update_history_stats();
        longint          sum;
        longint          sumsq;
        longint          n;
        longint unsigned dev;
        longint unsigned twice_sd;
        sum = 0;
        sumsq = 0;
        n = fill_cnt;
        for (int i = 0; i < fill_cnt; i++)
        begin
            sum += hist_ring[i];
            sumsq += hist_ring[i] * hist_ring[i];
        end
        mean_val = int'(div_floor(32 * sum + n, 2 * n));
        dev = n * sumsq - sum * sum;
        twice_sd = int_sqrt(dev * 1024) / n;
        stab_val = (twice_sd >= 1600) ? 0 : 1600 - int'(twice_sd);
    endfunction

    function automatic score_t score_measurement(meas_t m);
        int     rsrp;
        int     rsrq;
        int     sinr;
        int     q;
        int     st;
        int     rk;
        score_t s;
        rsrp = int'(m.rsrp_dbm);
        rsrq = int'(m.rsrq_db);
        sinr = int'(m.sinr_db);
        if (m.rsrp_valid && m.rsrq_valid && m.sinr_valid)
        begin
            hist_ring[slot_ptr] = rsrp;
            slot_ptr = (slot_ptr + 1 >= HISTORY_DEPTH) ? 0 : slot_ptr + 1;
            if (fill_cnt < HISTORY_DEPTH) fill_cnt++;
            if (fill_cnt >= 2) update_history_stats();
        end
        q = 100;
        if (m.rsrp_valid)
        begin
            if (rsrp >= -80) q = q;
            else if (rsrp >= -90) q -= 5;
            else if (rsrp >= -100) q -= 15;
            else if (rsrp >= -110) q -= 30;
            else q -= 50;
        end
        if (m.rsrq_valid)
        begin
            if (rsrq >= -10) q = q;
            else if (rsrq >= -15) q -= 5;
            else if (rsrq >= -20) q -= 15;
            else q -= 25;
        end
        if (m.sinr_valid)
        begin
            if (sinr >= 20) q += 10;
            else if (sinr >= 13) q += 5;
            else if (sinr < 0) q -= 20;
        end
        if (m.roaming) q -= 10;
        if (q < 0) q = 0;
        if (q > 100) q = 100;

        st = stab_val;
        if (m.seconds_since_cell_change < 300) st -= 320;
        else if (m.seconds_since_cell_change < 600) st -= 160;
        if (!m.connected) st -= 800;
        if (st < 0) st = 0;
        if (st > 1600) st = 1600;

        rk = 0;
        if (m.rsrp_valid)
        begin
            if (rsrp < -110) rk += 4;
            else if (rsrp < -100) rk += 2;
        end
        if (m.rsrq_valid)
        begin
            if (rsrq < -20) rk += 3;
            else if (rsrq < -15) rk += 1;
        end
        if (m.cell_changes_seen > chg_limit) rk += 2;
        if (stab_val < int'(stab_thr)) rk += 1;
        if (rk > 10) rk = 10;

        s.quality = q[6:0];
        s.stab_score = st[10:0];
        s.var_stab = stab_val[10:0];
        s.mean = mean_val[12:0];
        s.risk = rk[3:0];
        return s;
    endfunction

    function automatic meas_t mk_meas(int rsrp, int rsrq, int sinr, logic [2:0] flags,
                                      logic roam, logic conn, int since, int changes);
        meas_t m;
        m.rsrp_dbm = rsrp[8:0];
        m.rsrq_db = rsrq[6:0];
        m.sinr_db = sinr[6:0];
        {m.rsrp_valid, m.rsrq_valid, m.sinr_valid} = flags;
        m.roaming = roam;
        m.connected = conn;
        m.seconds_since_cell_change = since[15:0];
        m.cell_changes_seen = changes[15:0];
        return m;
    endfunction

    function automatic meas_t rand_meas();
        int          pick;
        logic [63:0] raw;
        meas_t       m;
        pick = $urandom_range(99);
        raw = {$urandom, $urandom};
        if (pick < 85)
            m = mk_meas($urandom_range(96) - 140, $urandom_range(37) - 34,
                        $urandom_range(63) - 23, 3'b111, ($urandom_range(9) == 0),
                        ($urandom_range(9) != 0), 0, 0);
        else
            m = raw[$bits(meas_t)-1:0];
        if (pick >= 95)
        begin
            m.rsrp_valid = 1'($urandom_range(1));
            m.rsrq_valid = 1'($urandom_range(1));
            m.sinr_valid = 1'($urandom_range(1));
        end
        else if (pick >= 85)
            {m.rsrp_valid, m.rsrq_valid, m.sinr_valid} = 3'b111;
        if (pick < 85)
        begin
            m.seconds_since_cell_change = ($urandom_range(3) == 0) ? 16'($urandom)
                                                                    : 16'($urandom_range(900));
            m.cell_changes_seen = ($urandom_range(3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(10));
        end
        return m;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic send_meas(meas_t m, logic typed, score_t s);
        score_t pred;
        if ($urandom_range(99) < snd_idle_pct)
        begin
            meas.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        meas.valid <= 1'b1;
        meas.rsrp_dbm <= m.rsrp_dbm;
        meas.rsrq_db <= m.rsrq_db;
        meas.sinr_db <= m.sinr_db;
        meas.rsrp_valid <= m.rsrp_valid;
        meas.rsrq_valid <= m.rsrq_valid;
        meas.sinr_valid <= m.sinr_valid;
        meas.roaming <= m.roaming;
        meas.connected <= m.connected;
        meas.seconds_since_cell_change <= m.seconds_since_cell_change;
        meas.cell_changes_seen <= m.cell_changes_seen;
        do @(posedge clk); while (!meas.ready);
        pred = score_measurement(m);
        score_q.push_back(typed ? s : pred);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_MAX_CHANGES) chg_limit = {16'd0, value};
        else if (idx == CFG_STAB_THR) stab_thr = {21'd0, value[10:0]};
    endtask

    task automatic drain();
        meas.valid <= 1'b0;
        while (score_q.size() != 0) @(posedge clk);
        // idle padding after the last result has been checked; the block is idle by then
        repeat (300) @(posedge clk);
    endtask

    // result checker and receiver stalls
    initial
    begin
        score_t want;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                if (score_q.size() == 0)
                    report("unexpected transaction", 0, 0);
                else
                begin
                    want = score_q.pop_front();
                    if (res.quality_score !== want.quality)
                        report("quality_score", res.quality_score, want.quality);
                    if (res.stab_score !== want.stab_score)
                        report("stab_score", res.stab_score, want.stab_score);
                    if (res.variance_stability !== want.var_stab)
                        report("variance_stability", res.variance_stability, want.var_stab);
                    if (res.mean_rsrp !== want.mean)
                        report("mean_rsrp", res.mean_rsrp, want.mean);
                    if (res.risk_tenths !== want.risk)
                        report("risk_tenths", res.risk_tenths, want.risk);
                end
            end
            res.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        score_t none;
        none = '0;
        n_errors = 0;
        snd_idle_pct = 24;
        rcv_idle_pct = 49;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist_ring[i] = 0;
        slot_ptr = 0;
        fill_cnt = 0;
        stab_val = 0;
        mean_val = 0;
        chg_limit = RST_MAX_CHANGES;
        stab_thr = RST_STAB_THR;
        rst_n <= 1'b0;
        meas.valid <= 1'b0;
        {meas.rsrp_dbm, meas.rsrq_db, meas.sinr_db, meas.rsrp_valid, meas.rsrq_valid,
         meas.sinr_valid, meas.roaming, meas.connected, meas.seconds_since_cell_change,
         meas.cell_changes_seen} <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_MAX_CHANGES;
        cfg.data <= '0;

        // after reset: no history, stability 0 so only the threshold term counts
        dir_tab.push_back('{mk_meas(-60, -5, 10, 3'b000, 0, 1, 1000, 0), 1'b1,
                            '{7'd100, 11'd0, 11'd0, 13'sd0, 4'd1}});
        // all fields at the bottom, one entry held, risk saturates
        dir_tab.push_back('{mk_meas(-140, -34, -23, 3'b111, 1, 0, 0, 65535), 1'b1,
                            '{7'd0, 11'd0, 11'd0, 13'sd0, 4'd10}});
        dir_tab.push_back('{mk_meas(-44, 3, 40, 3'b111, 0, 1, 65535, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-80, -10, 20, 3'b111, 0, 1, 299, 5), 1'b0, none});
        dir_tab.push_back('{mk_meas(-81, -11, 19, 3'b111, 0, 1, 300, 6), 1'b0, none});
        dir_tab.push_back('{mk_meas(-90, -15, 13, 3'b111, 0, 1, 599, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-91, -16, 12, 3'b111, 0, 0, 600, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-100, -20, 0, 3'b111, 1, 1, 0, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-101, -21, -1, 3'b111, 0, 1, 700, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-110, -5, 5, 3'b111, 0, 1, 700, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-111, -5, 5, 3'b100, 0, 1, 700, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-120, -30, -10, 3'b010, 0, 1, 700, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-70, -25, -10, 3'b001, 1, 0, 100, 0), 1'b0, none});
        // out-of-range values at full field width
        dir_tab.push_back('{mk_meas(255, 63, 63, 3'b111, 0, 1, 1000, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-256, -64, -64, 3'b111, 0, 1, 1000, 0), 1'b0, none});
        dir_tab.push_back('{mk_meas(-85, -12, 15, 3'b111, 0, 1, 43690, 21845), 1'b0, none});
        dir_tab.push_back('{mk_meas(-85, -12, 15, 3'b111, 0, 1, 21845, 43690), 1'b0, none});
        dir_tab.push_back('{mk_meas(-85, -12, 15, 3'b111, 0, 1, 1000, 0), 1'b0, none});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) send_meas(dir_tab[i].m, dir_tab[i].typed, dir_tab[i].s);
        drain();

        write_reg(CFG_MAX_CHANGES, 16'd0);
        write_reg(CFG_STAB_THR, 16'd0);
        repeat (500) send_meas(rand_meas(), 1'b0, none);
        drain();

        snd_idle_pct = 49;
        rcv_idle_pct = 24;
        write_reg(CFG_MAX_CHANGES, 16'hFFFF);
        write_reg(CFG_STAB_THR, 16'd1600);
        repeat (500) send_meas(rand_meas(), 1'b0, none);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(CFG_MAX_CHANGES, 16'($urandom_range(1, 20)));
        write_reg(CFG_STAB_THR, 16'd2047);   // above full scale: threshold term always set
        repeat (250) send_meas(rand_meas(), 1'b0, none);
        drain();
        write_reg(CFG_STAB_THR, 16'($urandom_range(800, 1500)));
        repeat (250) send_meas(rand_meas(), 1'b0, none);
        drain();

        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
